FILE: design/mkw_pkg.sv
// Package for the JPEG marker walker: payload types, marker codes and walk constants.
`default_nettype none
package mkw_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_window;
  } mkw_in_t;

  typedef struct packed {
    logic        image_found;
    logic [31:0] extract_length;
    logic [1:0]  stop_cause;
  } mkw_out_t;

  localparam logic [31:0] CRAWL_LIMIT_RESET = 32'd10485760;
  localparam logic [31:0] POS_MAX           = 32'hFFFF_FFFF;

  // Stop causes as they appear in the result.
  localparam logic [1:0] CAUSE_END   = 2'd0;
  localparam logic [1:0] CAUSE_PARSE = 2'd1;
  localparam logic [1:0] CAUSE_LIMIT = 2'd2;

  // Walk phases.
  localparam logic [2:0] PH_MARK  = 3'd0;
  localparam logic [2:0] PH_FF    = 3'd1;
  localparam logic [2:0] PH_LENHI = 3'd2;
  localparam logic [2:0] PH_LENLO = 3'd3;
  localparam logic [2:0] PH_SKIP  = 3'd4;

  localparam logic [7:0] MK_PREFIX = 8'hFF;
  localparam logic [7:0] MK_SOI    = 8'hD8;
  localparam logic [7:0] MK_SOS    = 8'hDA;
  localparam logic [7:0] MK_EOI    = 8'hD9;

  // Markers that carry a big-endian length and a body to skip.
  function automatic logic is_segment(input logic [7:0] b);
    logic r;
    case (b) inside
      8'hDC, 8'hC4, 8'hC0, 8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hDD, 8'hDB: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/mkw_walker.sv
// Marker walk state and the per-byte decision logic, including the crawl limit register.
`default_nettype none
module mkw_walker (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [31:0]      cfg_data_i,
  input  wire logic             accept_i,
  input  wire mkw_pkg::mkw_in_t item_i,
  output logic                  res_valid_o,
  output mkw_pkg::mkw_out_t     res_o
);
  import mkw_pkg::*;

  logic [31:0] limit_q;
  logic [31:0] pos_q, pos_d;
  logic [2:0]  phase_q, phase_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] skip_q, skip_d;
  logic        scan_q, scan_d;
  logic        eoi_q, eoi_d;
  logic [31:0] eoi_pos_q, eoi_pos_d;
  logic        stopped_q, stopped_d;

  logic [7:0]  b;
  logic        eow;
  logic        limit_hit;
  logic [31:0] pos_inc;
  logic [15:0] seg_len;
  logic [1:0]  cause;
  logic        found;

  assign b         = item_i.data_byte;
  assign eow       = item_i.end_of_window;
  assign limit_hit = pos_q > limit_q;
  assign pos_inc   = (pos_q == POS_MAX) ? pos_q : pos_q + 32'd1;
  assign seg_len   = {len_hi_q, b};

  always_comb begin
    phase_d   = phase_q;
    len_hi_d  = len_hi_q;
    skip_d    = skip_q;
    scan_d    = scan_q;
    eoi_d     = eoi_q;
    eoi_pos_d = eoi_pos_q;
    cause     = CAUSE_END;

    if (!stopped_q) begin
      case (phase_q)
        PH_FF: begin
          if (b == MK_SOI || b == MK_SOS) begin
            if (b == MK_SOS) scan_d = 1'b1;
            eoi_d   = 1'b0;
            phase_d = PH_MARK;
          end else if (is_segment(b)) begin
            eoi_d   = 1'b0;
            phase_d = PH_LENHI;
          end else if (b == MK_EOI) begin
            eoi_d     = 1'b1;
            scan_d    = 1'b0;
            eoi_pos_d = pos_inc;
            phase_d   = PH_MARK;
          end else if (scan_q) begin
            // Inside a scan the second byte starts a fresh marker decision.
            if (limit_hit) begin
              cause = CAUSE_LIMIT;
            end else if (b == MK_PREFIX) begin
              phase_d = PH_FF;
            end else begin
              phase_d = PH_MARK;
            end
          end else begin
            cause = CAUSE_PARSE;
          end
        end
        PH_LENHI: begin
          len_hi_d = b;
          phase_d  = PH_LENLO;
        end
        PH_LENLO: begin
          if (seg_len < 16'd2) begin
            cause = CAUSE_PARSE;
          end else begin
            skip_d  = seg_len - 16'd2;
            phase_d = (seg_len == 16'd2) ? PH_MARK : PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_d = skip_q - 16'd1;
          if (skip_q == 16'd1) phase_d = PH_MARK;
        end
        default: begin
          if (limit_hit) begin
            cause = CAUSE_LIMIT;
          end else if (b == MK_PREFIX) begin
            phase_d = PH_FF;
          end else begin
            phase_d = PH_MARK;
            if (!scan_q) cause = CAUSE_PARSE;
          end
        end
      endcase
    end

    res_valid_o = accept_i && !stopped_q && (cause != CAUSE_END || eow);
    found       = (cause != CAUSE_LIMIT) && eoi_d;
    res_o.image_found    = found;
    res_o.extract_length = found ? eoi_pos_d : 32'd0;
    res_o.stop_cause     = cause;

    stopped_d = stopped_q || res_valid_o;
    pos_d     = pos_inc;

    // The final byte of a window returns the walk to its reset state.
    if (eow) begin
      pos_d     = '0;
      phase_d   = PH_MARK;
      len_hi_d  = '0;
      skip_d    = '0;
      scan_d    = 1'b0;
      eoi_d     = 1'b0;
      eoi_pos_d = '0;
      stopped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= CRAWL_LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      phase_q   <= PH_MARK;
      len_hi_q  <= '0;
      skip_q    <= '0;
      scan_q    <= 1'b0;
      eoi_q     <= 1'b0;
      eoi_pos_q <= '0;
      stopped_q <= 1'b0;
    end else if (accept_i) begin
      pos_q     <= pos_d;
      phase_q   <= phase_d;
      len_hi_q  <= len_hi_d;
      skip_q    <= skip_d;
      scan_q    <= scan_d;
      eoi_q     <= eoi_d;
      eoi_pos_q <= eoi_pos_d;
      stopped_q <= stopped_d;
    end
  end

endmodule
`default_nettype wire

FILE: design/mkw_out_buf.sv
// Result register with a skid entry, so the input side never waits on the output stall combinationally.
`default_nettype none
module mkw_out_buf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              res_valid_i,
  input  wire mkw_pkg::mkw_out_t res_i,
  output logic                   full_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output mkw_pkg::mkw_out_t      out_data_o
);
  import mkw_pkg::*;

  logic     main_valid_q;
  logic     skid_valid_q;
  mkw_out_t main_q;
  mkw_out_t skid_q;
  logic     main_free;

  assign main_free   = !main_valid_q || !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // No new result arrives while the skid entry is occupied.
      if (main_free) begin
        main_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid_i) begin
      if (main_free) begin
        main_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (main_free) begin
      main_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (main_free) main_q <= skid_q;
    end else if (res_valid_i) begin
      if (main_free) begin
        main_q <= res_i;
      end else begin
        skid_q <= res_i;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/jpeg_marker_walker.sv
// Top level of the JPEG marker walker.
// Walks the marker structure of a byte window that starts at a candidate JPEG start, one byte
// per transfer, and gives one result per window: when the walk stops on a parse error or the
// crawl limit, or else with the window's final byte. Walk state and result are registered when
// the byte is taken. A result register plus one skid entry sit on the output: a result goes to
// the skid entry while the result register is stalled, so input transfers continue while a
// result waits; in_stall_o rises only once both hold a result. The user must write crawl_limit
// through cfg_we_i/cfg_data_i only while the block is idle; the block does not enforce it.
`default_nettype none
module jpeg_marker_walker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [31:0]       cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire mkw_pkg::mkw_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output mkw_pkg::mkw_out_t      out_data_o
);
  import mkw_pkg::*;

  logic     accept;
  logic     res_valid;
  mkw_out_t res;
  logic     buf_full;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  mkw_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .item_i      (in_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mkw_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

FILE: design/mkw_checker.sv
// Port-level checks for the JPEG marker walker and the bind that attaches them.
`default_nettype none
module mkw_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              cfg_we_i,
  input wire logic [31:0]       cfg_data_i,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire mkw_pkg::mkw_in_t  in_data_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire mkw_pkg::mkw_out_t out_data_o
);
  import mkw_pkg::*;

  // A stalled result stays in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // The input side backs up only after the output side was stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without output stall");

  // The skid entry drains as soon as the output is not stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_stall_i |=> !in_stall_o)
    else $error("input stall held after output drained");

  // A found image never comes with the crawl limit cause, and always has a length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.image_found |->
      out_data_o.stop_cause != CAUSE_LIMIT && out_data_o.extract_length != 32'd0)
    else $error("found image with bad cause or length");

endmodule

bind jpeg_marker_walker mkw_checker u_mkw_checker (.*);
`default_nettype wire
